// ===== hdl/fwsc_pkg.sv =====
// Shared types and constants of the flow window stability calibrator.
package fwsc_pkg;

	localparam int COUNT_BITS = 16;
	localparam int FLOW_W     = 24;
	localparam int SUM_W      = FLOW_W + COUNT_BITS;
	localparam int SQ_W       = 2 * FLOW_W;
	localparam int SQSUM_W    = 64;
	localparam int DIVD_W     = 64;
	localparam int DIVS_W     = 48;
	localparam int ITER_W     = 7;
	localparam int ROOT_W     = 24;
	localparam int SREM_W     = ROOT_W + 3;
	localparam int NUM_W      = 39;
	localparam int LIM_W      = 40;
	localparam int KPROD_W    = 41;
	localparam int B_W        = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [14:0] CV_SCALE = 15'd25600;
	localparam logic [FLOW_W-1:0] KNEE_FLOOR = 24'd256;
	localparam logic [15:0] CV_MAX = 16'hFFFF;
	localparam logic [ITER_W-1:0] DIV_ITERS = 7'd64;
	localparam logic [ITER_W-1:0] SQRT_ITERS = 7'd24;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_FLOOR   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CEILING = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_FRACTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STAB_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_FLOW = 3'd4;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_GAIN_ORDER = 3'd1,
		ST_KNEE_RANGE = 3'd2,
		ST_NO_SAMPLES = 3'd3,
		ST_ZERO_MEAN  = 3'd4,
		ST_UNSTABLE   = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_SQUARE, OP_ACCUM, OP_MEAN_LD, OP_DIV_STEP, OP_MEAN_SAVE,
		OP_MSQ_LD, OP_MSQ_SAVE, OP_VAR, OP_SQRT_STEP, OP_NUM, OP_CV_LD, OP_CV_SAVE,
		OP_ERR, OP_KNEE, OP_KSQ, OP_B_LD, OP_B_SAVE, OP_FINISH
	} dp_op_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SQUARE, S_ACCUM, S_MEAN_LD, S_MEAN_RUN, S_MEAN_SAVE, S_MSQ_LD,
		S_MSQ_RUN, S_MSQ_SAVE, S_VAR, S_SQRT_RUN, S_NUM, S_CV_LD, S_CV_RUN, S_CV_SAVE,
		S_ERR, S_KNEE, S_KSQ, S_B_LD, S_B_RUN, S_B_SAVE, S_FINISH
	} state_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic iter_last;
		logic count_zero;
		logic quot_zero;
		logic eval_ok;
		logic window_end;
	} dp_status_t;

	typedef struct packed {
		logic [31:0]       gain_floor;
		logic [31:0]       gain_ceiling;
		logic [16:0]       knee_fraction;
		logic [15:0]       stability_limit;
		logic [FLOW_W-1:0] nominal_flow;
	} cfg_t;

endpackage

// ===== hdl/fwsc_ctrl.sv =====
// Controller state machine that sequences accumulation and window evaluation.
module fwsc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  fwsc_pkg::dp_status_t st,
	output fwsc_pkg::dp_cmd_t   cmd,
	output logic                busy
);

	fwsc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fwsc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op = fwsc_pkg::OP_NONE;
		busy = (state_q != fwsc_pkg::S_IDLE);
		case (state_q)
			fwsc_pkg::S_IDLE: begin
				if (start) begin
					cmd.op = fwsc_pkg::OP_LATCH;
					state_d = fwsc_pkg::S_SQUARE;
				end
			end
			fwsc_pkg::S_SQUARE: begin
				cmd.op = fwsc_pkg::OP_SQUARE;
				state_d = fwsc_pkg::S_ACCUM;
			end
			fwsc_pkg::S_ACCUM: begin
				cmd.op = fwsc_pkg::OP_ACCUM;
				state_d = st.window_end ? fwsc_pkg::S_MEAN_LD : fwsc_pkg::S_IDLE;
			end
			fwsc_pkg::S_MEAN_LD: begin
				if (st.count_zero) begin
					state_d = fwsc_pkg::S_FINISH;
				end else begin
					cmd.op = fwsc_pkg::OP_MEAN_LD;
					state_d = fwsc_pkg::S_MEAN_RUN;
				end
			end
			fwsc_pkg::S_MEAN_RUN: begin
				cmd.op = fwsc_pkg::OP_DIV_STEP;
				if (st.iter_last) state_d = fwsc_pkg::S_MEAN_SAVE;
			end
			fwsc_pkg::S_MEAN_SAVE: begin
				cmd.op = fwsc_pkg::OP_MEAN_SAVE;
				state_d = st.quot_zero ? fwsc_pkg::S_FINISH : fwsc_pkg::S_MSQ_LD;
			end
			fwsc_pkg::S_MSQ_LD: begin
				cmd.op = fwsc_pkg::OP_MSQ_LD;
				state_d = fwsc_pkg::S_MSQ_RUN;
			end
			fwsc_pkg::S_MSQ_RUN: begin
				cmd.op = fwsc_pkg::OP_DIV_STEP;
				if (st.iter_last) state_d = fwsc_pkg::S_MSQ_SAVE;
			end
			fwsc_pkg::S_MSQ_SAVE: begin
				cmd.op = fwsc_pkg::OP_MSQ_SAVE;
				state_d = fwsc_pkg::S_VAR;
			end
			fwsc_pkg::S_VAR: begin
				cmd.op = fwsc_pkg::OP_VAR;
				state_d = fwsc_pkg::S_SQRT_RUN;
			end
			fwsc_pkg::S_SQRT_RUN: begin
				cmd.op = fwsc_pkg::OP_SQRT_STEP;
				if (st.iter_last) state_d = fwsc_pkg::S_NUM;
			end
			fwsc_pkg::S_NUM: begin
				cmd.op = fwsc_pkg::OP_NUM;
				state_d = fwsc_pkg::S_CV_LD;
			end
			fwsc_pkg::S_CV_LD: begin
				cmd.op = fwsc_pkg::OP_CV_LD;
				state_d = fwsc_pkg::S_CV_RUN;
			end
			fwsc_pkg::S_CV_RUN: begin
				cmd.op = fwsc_pkg::OP_DIV_STEP;
				if (st.iter_last) state_d = fwsc_pkg::S_CV_SAVE;
			end
			fwsc_pkg::S_CV_SAVE: begin
				cmd.op = fwsc_pkg::OP_CV_SAVE;
				state_d = st.eval_ok ? fwsc_pkg::S_ERR : fwsc_pkg::S_FINISH;
			end
			fwsc_pkg::S_ERR: begin
				cmd.op = fwsc_pkg::OP_ERR;
				state_d = fwsc_pkg::S_KNEE;
			end
			fwsc_pkg::S_KNEE: begin
				cmd.op = fwsc_pkg::OP_KNEE;
				state_d = fwsc_pkg::S_KSQ;
			end
			fwsc_pkg::S_KSQ: begin
				cmd.op = fwsc_pkg::OP_KSQ;
				state_d = fwsc_pkg::S_B_LD;
			end
			fwsc_pkg::S_B_LD: begin
				cmd.op = fwsc_pkg::OP_B_LD;
				state_d = fwsc_pkg::S_B_RUN;
			end
			fwsc_pkg::S_B_RUN: begin
				cmd.op = fwsc_pkg::OP_DIV_STEP;
				if (st.iter_last) state_d = fwsc_pkg::S_B_SAVE;
			end
			fwsc_pkg::S_B_SAVE: begin
				cmd.op = fwsc_pkg::OP_B_SAVE;
				state_d = fwsc_pkg::S_FINISH;
			end
			fwsc_pkg::S_FINISH: begin
				cmd.op = fwsc_pkg::OP_FINISH;
				state_d = fwsc_pkg::S_IDLE;
			end
			default: begin
				state_d = fwsc_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/fwsc_datapath.sv =====
// Datapath with accumulators, shared serial divider, serial square root and result registers.
module fwsc_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fwsc_pkg::dp_cmd_t                 cmd,
	input  fwsc_pkg::cfg_t                    cfg,
	input  logic [fwsc_pkg::FLOW_W-1:0]       flow_sample,
	input  logic                              sample_valid,
	input  logic                              window_end,
	output fwsc_pkg::dp_status_t              st,
	output logic                              done,
	output logic [2:0]                        status,
	output logic [fwsc_pkg::FLOW_W-1:0]       mean_flow,
	output logic [15:0]                       variation_pct,
	output logic [fwsc_pkg::FLOW_W-1:0]       knee_error,
	output logic [fwsc_pkg::B_W-1:0]          curve_b,
	output logic [fwsc_pkg::B_W-1:0]          soft_curve_b
);

	logic [fwsc_pkg::FLOW_W-1:0]     fs_q;
	logic                            valid_q;
	logic                            end_q;
	logic [fwsc_pkg::SQ_W-1:0]       sq_q;
	logic                            add_q;
	logic [fwsc_pkg::COUNT_BITS-1:0] count_q;
	logic [fwsc_pkg::SUM_W-1:0]      sum_q;
	logic [fwsc_pkg::SQSUM_W-1:0]    sqsum_q;
	logic [fwsc_pkg::SQSUM_W:0]      sqsum_add;

	logic [fwsc_pkg::DIVD_W-1:0]     div_num_q;
	logic [fwsc_pkg::DIVS_W-1:0]     div_den_q;
	logic [fwsc_pkg::DIVS_W-1:0]     div_rem_q;
	logic [fwsc_pkg::DIVS_W:0]       div_trial;
	logic [fwsc_pkg::ITER_W-1:0]     iter_q;

	logic [fwsc_pkg::SQ_W-1:0]       sqrt_val_q;
	logic [fwsc_pkg::SREM_W-1:0]     sqrt_rem_q;
	logic [fwsc_pkg::ROOT_W-1:0]     root_q;
	logic [fwsc_pkg::SREM_W-1:0]     sqrt_sh;
	logic [fwsc_pkg::SREM_W-1:0]     sqrt_trial;

	logic [fwsc_pkg::FLOW_W-1:0]     mean_q;
	logic [fwsc_pkg::SQ_W-1:0]       msq_q;
	logic [fwsc_pkg::SQ_W-1:0]       m2_q;
	logic [fwsc_pkg::NUM_W-1:0]      num_q;
	logic [fwsc_pkg::LIM_W-1:0]      lim_q;
	logic                            unstable_q;
	logic [15:0]                     cv_q;
	logic [fwsc_pkg::FLOW_W-1:0]     err_q;
	logic [fwsc_pkg::KPROD_W-1:0]    kprod_q;
	logic [fwsc_pkg::FLOW_W-1:0]     knee_q;
	logic [fwsc_pkg::FLOW_W-1:0]     knee_c;
	logic [fwsc_pkg::SQ_W-1:0]       ksq_q;
	logic [fwsc_pkg::B_W-1:0]        b_q;

	logic                            gains_bad;
	logic                            knee_bad;
	fwsc_pkg::status_t               status_c;

	logic                            done_q;
	logic [2:0]                      status_q;
	logic [fwsc_pkg::FLOW_W-1:0]     mean_out_q;
	logic [15:0]                     cv_out_q;
	logic [fwsc_pkg::FLOW_W-1:0]     knee_out_q;
	logic [fwsc_pkg::B_W-1:0]        b_out_q;

	assign sqsum_add = {1'b0, sqsum_q} + (fwsc_pkg::SQSUM_W+1)'(sq_q);
	assign div_trial = {div_rem_q, div_num_q[fwsc_pkg::DIVD_W-1]};
	assign sqrt_sh = {sqrt_rem_q[fwsc_pkg::SREM_W-3:0],
		sqrt_val_q[fwsc_pkg::SQ_W-1 -: 2]};
	assign sqrt_trial = {1'b0, root_q, 2'b01};
	assign knee_c = (kprod_q[39:16] < fwsc_pkg::KNEE_FLOOR) ? fwsc_pkg::KNEE_FLOOR
		: kprod_q[39:16];

	assign gains_bad = (cfg.gain_ceiling <= cfg.gain_floor);
	assign knee_bad = (cfg.knee_fraction == '0) || cfg.knee_fraction[16];

	always_comb begin
		if (gains_bad) begin
			status_c = fwsc_pkg::ST_GAIN_ORDER;
		end else if (knee_bad) begin
			status_c = fwsc_pkg::ST_KNEE_RANGE;
		end else if (count_q == '0) begin
			status_c = fwsc_pkg::ST_NO_SAMPLES;
		end else if (mean_q == '0) begin
			status_c = fwsc_pkg::ST_ZERO_MEAN;
		end else if (unstable_q) begin
			status_c = fwsc_pkg::ST_UNSTABLE;
		end else begin
			status_c = fwsc_pkg::ST_OK;
		end
	end

	assign st.iter_last  = (iter_q == fwsc_pkg::ITER_W'(1));
	assign st.count_zero = (count_q == '0);
	assign st.quot_zero  = (div_num_q == '0);
	assign st.eval_ok    = !gains_bad && !knee_bad && !unstable_q;
	assign st.window_end = end_q;

	// Accumulators and output strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q <= '0;
			sqsum_q <= '0;
			done_q <= 1'b0;
			end_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (cmd.op)
				fwsc_pkg::OP_LATCH: begin
					end_q <= window_end;
				end
				fwsc_pkg::OP_ACCUM: begin
					if (add_q) begin
						count_q <= count_q + 1'b1;
						sum_q <= sum_q + fwsc_pkg::SUM_W'(fs_q);
						sqsum_q <= sqsum_add[fwsc_pkg::SQSUM_W] ? '1
							: sqsum_add[fwsc_pkg::SQSUM_W-1:0];
					end
				end
				fwsc_pkg::OP_MEAN_LD, fwsc_pkg::OP_MSQ_LD, fwsc_pkg::OP_CV_LD,
				fwsc_pkg::OP_B_LD: begin
					iter_q <= fwsc_pkg::DIV_ITERS;
				end
				fwsc_pkg::OP_VAR: begin
					iter_q <= fwsc_pkg::SQRT_ITERS;
				end
				fwsc_pkg::OP_DIV_STEP, fwsc_pkg::OP_SQRT_STEP: begin
					if (iter_q != '0) iter_q <= iter_q - 1'b1;
				end
				fwsc_pkg::OP_FINISH: begin
					done_q <= 1'b1;
					count_q <= '0;
					sum_q <= '0;
					sqsum_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (cmd.op)
			fwsc_pkg::OP_LATCH: begin
				fs_q <= flow_sample;
				valid_q <= sample_valid;
			end
			fwsc_pkg::OP_SQUARE: begin
				sq_q <= fwsc_pkg::SQ_W'(fs_q) * fwsc_pkg::SQ_W'(fs_q);
				add_q <= valid_q && (count_q != fwsc_pkg::COUNT_MAX);
			end
			fwsc_pkg::OP_MEAN_LD: begin
				div_num_q <= fwsc_pkg::DIVD_W'(sum_q);
				div_den_q <= fwsc_pkg::DIVS_W'(count_q);
				div_rem_q <= '0;
			end
			fwsc_pkg::OP_MSQ_LD: begin
				div_num_q <= sqsum_q;
				div_den_q <= fwsc_pkg::DIVS_W'(count_q);
				div_rem_q <= '0;
			end
			fwsc_pkg::OP_CV_LD: begin
				unstable_q <= fwsc_pkg::LIM_W'(num_q) > lim_q;
				div_num_q <= fwsc_pkg::DIVD_W'(num_q);
				div_den_q <= fwsc_pkg::DIVS_W'(mean_q);
				div_rem_q <= '0;
			end
			fwsc_pkg::OP_B_LD: begin
				div_num_q <= {2'b00, cfg.gain_ceiling - cfg.gain_floor, 30'd0};
				div_den_q <= ksq_q;
				div_rem_q <= '0;
			end
			fwsc_pkg::OP_DIV_STEP: begin
				if (iter_q != '0) begin
					if (div_trial >= {1'b0, div_den_q}) begin
						div_rem_q <= fwsc_pkg::DIVS_W'(div_trial - {1'b0, div_den_q});
						div_num_q <= {div_num_q[fwsc_pkg::DIVD_W-2:0], 1'b1};
					end else begin
						div_rem_q <= div_trial[fwsc_pkg::DIVS_W-1:0];
						div_num_q <= {div_num_q[fwsc_pkg::DIVD_W-2:0], 1'b0};
					end
				end
			end
			fwsc_pkg::OP_MEAN_SAVE: begin
				mean_q <= div_num_q[fwsc_pkg::FLOW_W-1:0];
			end
			fwsc_pkg::OP_MSQ_SAVE: begin
				msq_q <= div_num_q[fwsc_pkg::SQ_W-1:0];
				m2_q <= fwsc_pkg::SQ_W'(mean_q) * fwsc_pkg::SQ_W'(mean_q);
			end
			fwsc_pkg::OP_VAR: begin
				sqrt_val_q <= (msq_q > m2_q) ? (msq_q - m2_q) : '0;
				sqrt_rem_q <= '0;
				root_q <= '0;
			end
			fwsc_pkg::OP_SQRT_STEP: begin
				if (iter_q != '0) begin
					sqrt_val_q <= {sqrt_val_q[fwsc_pkg::SQ_W-3:0], 2'b00};
					if (sqrt_sh >= sqrt_trial) begin
						sqrt_rem_q <= sqrt_sh - sqrt_trial;
						root_q <= {root_q[fwsc_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						sqrt_rem_q <= sqrt_sh;
						root_q <= {root_q[fwsc_pkg::ROOT_W-2:0], 1'b0};
					end
				end
			end
			fwsc_pkg::OP_NUM: begin
				num_q <= fwsc_pkg::NUM_W'(fwsc_pkg::CV_SCALE) * fwsc_pkg::NUM_W'(root_q);
				lim_q <= fwsc_pkg::LIM_W'(cfg.stability_limit) * fwsc_pkg::LIM_W'(mean_q);
			end
			fwsc_pkg::OP_CV_SAVE: begin
				cv_q <= (div_num_q > fwsc_pkg::DIVD_W'(fwsc_pkg::CV_MAX)) ? fwsc_pkg::CV_MAX
					: div_num_q[15:0];
			end
			fwsc_pkg::OP_ERR: begin
				err_q <= (cfg.nominal_flow >= mean_q) ? (cfg.nominal_flow - mean_q)
					: (mean_q - cfg.nominal_flow);
			end
			fwsc_pkg::OP_KNEE: begin
				kprod_q <= fwsc_pkg::KPROD_W'(cfg.knee_fraction) * fwsc_pkg::KPROD_W'(err_q);
			end
			fwsc_pkg::OP_KSQ: begin
				knee_q <= knee_c;
				ksq_q <= fwsc_pkg::SQ_W'(knee_c) * fwsc_pkg::SQ_W'(knee_c);
			end
			fwsc_pkg::OP_B_SAVE: begin
				b_q <= div_num_q[fwsc_pkg::B_W-1:0];
			end
			fwsc_pkg::OP_FINISH: begin
				status_q <= status_c;
				mean_out_q <= (count_q == '0) ? '0 : mean_q;
				cv_out_q <= ((count_q == '0) || (mean_q == '0)) ? '0 : cv_q;
				knee_out_q <= (status_c == fwsc_pkg::ST_OK) ? knee_q : '0;
				b_out_q <= (status_c == fwsc_pkg::ST_OK) ? b_q : '0;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign status = status_q;
	assign mean_flow = mean_out_q;
	assign variation_pct = cv_out_q;
	assign knee_error = knee_out_q;
	assign curve_b = b_out_q;
	assign soft_curve_b = {1'b0, b_out_q[fwsc_pkg::B_W-1:1]};

endmodule

// ===== hdl/flow_window_stability_calibrator_top.sv =====
// Top level of the flow window stability calibrator with its configuration registers.
// A sample is latched when start is taken; busy then stays high through the square and accumulate states.
// A window end keeps busy high through four 64-step serial divisions, a 24-step serial square root
// and 14 single steps; an empty window, a zero mean, a bad configuration or an unstable window ends early.
// The receiver cannot stall; done is high for one cycle, the first one after busy falls.
// Reset clears the accumulators and loads the configuration registers with their defaults.
module flow_window_stability_calibrator_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [fwsc_pkg::FLOW_W-1:0]         flow_sample,
	input  logic                                sample_valid,
	input  logic                                window_end,
	input  logic                                cfg_we,
	input  logic [fwsc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fwsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                done,
	output logic [2:0]                          status,
	output logic [fwsc_pkg::FLOW_W-1:0]         mean_flow,
	output logic [15:0]                         variation_pct,
	output logic [fwsc_pkg::FLOW_W-1:0]         knee_error,
	output logic [fwsc_pkg::B_W-1:0]            curve_b,
	output logic [fwsc_pkg::B_W-1:0]            soft_curve_b
);

	fwsc_pkg::cfg_t       cfg_q;
	fwsc_pkg::dp_cmd_t    cmd;
	fwsc_pkg::dp_status_t dp_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_floor <= 32'd0;
			cfg_q.gain_ceiling <= 32'd65536;
			cfg_q.knee_fraction <= 17'd32768;
			cfg_q.stability_limit <= 16'd1280;
			cfg_q.nominal_flow <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fwsc_pkg::REG_GAIN_FLOOR: cfg_q.gain_floor <= cfg_data;
				fwsc_pkg::REG_GAIN_CEILING: cfg_q.gain_ceiling <= cfg_data;
				fwsc_pkg::REG_KNEE_FRACTION: cfg_q.knee_fraction <= cfg_data[16:0];
				fwsc_pkg::REG_STAB_LIMIT: cfg_q.stability_limit <= cfg_data[15:0];
				fwsc_pkg::REG_NOMINAL_FLOW: begin
					cfg_q.nominal_flow <= cfg_data[fwsc_pkg::FLOW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	fwsc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.st     (dp_st),
		.cmd    (cmd),
		.busy   (busy)
	);

	fwsc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg           (cfg_q),
		.flow_sample   (flow_sample),
		.sample_valid  (sample_valid),
		.window_end    (window_end),
		.st            (dp_st),
		.done          (done),
		.status        (status),
		.mean_flow     (mean_flow),
		.variation_pct (variation_pct),
		.knee_error    (knee_error),
		.curve_b       (curve_b),
		.soft_curve_b  (soft_curve_b)
	);

endmodule
